>>> rtl/core/fct_pkg.sv
// Package for the flow counter table: status codes and shared types.
package fct_pkg;

    localparam int KEY_W   = 104;
    localparam int LEN_W   = 16;
    localparam int TS_W    = 64;
    localparam int CNT_W   = 48;
    localparam int SLOT_W  = 8;
    localparam int STAT_W  = 2;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_UPDATED = 2'd1,
        ST_INSERTED = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    // entry of the queue between front and back
    typedef struct packed {
        logic             ipv4;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [TS_W-1:0]  ts;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_OUT
    } t_state;

endpackage

>>> rtl/core/flow_counter_table_core.sv
// Top level of the flow counter table.
//  channel | dir | tdata fields (low bit up)                      | tuser
//  s_axis  | in  | src addr, dst addr, sport, dport, proto, len, ts | ipv4
//  m_axis  | out | slot, packets, bytes                           | status
// The back end works on one packet at a time; its key scan reads one entry a
// cycle through the flows in use and stops at a hit. An input transfer is
// registered in the front queue before it reaches the back end.
// Synchronous active-low reset clears the flow count; the table needs no clear.
// A two-entry queue lets input transfers continue while a result waits.
module flow_counter_table_core
    import fct_pkg::*;
#(
    parameter int FLOW_ENTRIES = 256
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [183:0] s_axis_tdata,  // src,dst,sport,dport,proto,len,ts
    input  logic         s_axis_tuser,  // ipv4
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // slot,packets,bytes
    output logic [1:0]   m_axis_tuser   // status
);
    t_job jb;
    logic jv, jr;
    logic [STAT_W-1:0] st;
    logic [SLOT_W-1:0] sl;
    logic [CNT_W-1:0]  pk, by;

    fct_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_ipv4(s_axis_tuser),
        .i_key(s_axis_tdata[103:0]),
        .i_len(s_axis_tdata[119:104]),
        .i_ts(s_axis_tdata[183:120]),
        .o_valid(jv), .i_ready(jr), .o_job(jb)
    );

    fct_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(jv), .o_ready(jr), .i_job(jb),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(st), .o_slot(sl), .o_pkts(pk), .o_bytes(by)
    );

    assign m_axis_tdata = {by, pk, sl};
    assign m_axis_tuser = st;

endmodule

>>> rtl/core/fct_front.sv
// Front part: accepts packet transfers and queues them with their IPv4 flag.
module fct_front
    import fct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_ipv4,
    input  logic [KEY_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_len,
    input  logic [TS_W-1:0]  i_ts,
    output logic        o_valid,
    input  logic        i_ready,
    output t_job        o_job
);
    // two-entry queue
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp].ipv4 <= i_ipv4;
            r_q[r_wp].key  <= i_key;
            r_q[r_wp].len  <= i_len;
            r_q[r_wp].ts   <= i_ts;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !rd) |=> r_cnt == 2'd2)
        else $error("full queue lost an entry");
`endif

endmodule

>>> rtl/core/fct_back.sv
// Back part: ignores non-IPv4, scans the table, updates, inserts or drops when full, and holds the result.
module fct_back
    import fct_pkg::*;
#(
    parameter int FLOW_ENTRIES = 256
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic [CNT_W-1:0]  o_pkts,
    output logic [CNT_W-1:0]  o_bytes
);
    localparam int IW = $clog2(FLOW_ENTRIES);
    localparam int CW = $clog2(FLOW_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(FLOW_ENTRIES);

    logic [KEY_W-1:0] m_key  [FLOW_ENTRIES];
    logic [CNT_W-1:0] m_pkts [FLOW_ENTRIES];
    logic [CNT_W-1:0] m_byts [FLOW_ENTRIES];
    logic [TS_W-1:0]  m_ts   [FLOW_ENTRIES];

    t_state r_st, n_st;
    t_job   r_job;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_idx, n_idx;
    logic [KEY_W-1:0] r_rkey;
    logic [CNT_W-1:0] r_rpk, r_rby;
    logic [IW-1:0] r_slot;
    logic [STAT_W-1:0] r_status;
    logic [CNT_W-1:0]  r_opk, r_oby;
    logic r_kvalid;   // r_rkey holds entry r_idx-1

    logic take, done, hit, ins, drop;
    logic [IW-1:0] ridx;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign take    = i_valid && o_ready;
    assign done    = o_valid && i_ready;
    assign ridx    = r_idx[IW-1:0];
    assign hit     = r_kvalid && (r_rkey == r_job.key);
    // scan exhausted: everything read and compared
    assign ins  = !hit && (r_idx == r_used) && !r_kvalid && r_used != FULL;
    assign drop = !hit && (r_idx == r_used) && !r_kvalid && r_used == FULL;

    always_comb begin
        n_st  = r_st;
        n_idx = r_idx;
        unique case (r_st)
            S_IDLE: if (take) begin
                n_idx = '0;
                n_st  = i_job.ipv4 ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                if (hit)            n_st = S_RMW_RD;
                else if (ins || drop) n_st = S_OUT;
                else if (r_idx != r_used) n_idx = r_idx + CW'(1);
            end
            S_RMW_RD: n_st = S_RMW_WR;
            S_RMW_WR: n_st = S_OUT;
            S_OUT:    if (done) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_st == S_SCAN && r_idx != r_used && !hit)
            r_rkey <= m_key[ridx];
        if (r_st == S_RMW_RD) begin
            r_rpk <= m_pkts[r_slot];
            r_rby <= m_byts[r_slot];
        end
        if (r_st == S_RMW_WR) begin
            m_pkts[r_slot] <= r_rpk + CNT_W'(1);
            m_byts[r_slot] <= r_rby + CNT_W'(r_job.len);
            m_ts[r_slot]   <= r_job.ts;
        end else if (r_st == S_SCAN && ins) begin
            m_key[ridx]  <= r_job.key;
            m_pkts[ridx] <= CNT_W'(1);
            m_byts[ridx] <= CNT_W'(r_job.len);
            m_ts[ridx]   <= r_job.ts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_job <= i_job;
        if (r_st == S_IDLE && take) begin
            r_status <= ST_IGNORED;
            r_opk <= '0;
            r_oby <= '0;
            r_slot <= '0;
        end
        if (r_st == S_SCAN) begin
            if (hit) begin
                r_slot <= IW'(r_idx - CW'(1));
                r_status <= ST_UPDATED;
            end else if (ins) begin
                r_slot <= ridx;
                r_status <= ST_INSERTED;
                r_opk <= CNT_W'(1);
                r_oby <= CNT_W'(r_job.len);
            end else if (drop) begin
                r_status <= ST_DROPPED;
            end
        end
        if (r_st == S_RMW_WR) begin
            r_opk <= r_rpk + CNT_W'(1);
            r_oby <= r_rby + CNT_W'(r_job.len);
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_used <= '0;
            r_idx <= '0;
            r_kvalid <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_idx <= n_idx;
            r_kvalid <= (r_st == S_SCAN) && !hit && (r_idx != r_used);
            if (r_st == S_SCAN && ins) r_used <= r_used + CW'(1);
        end
    end

    assign o_status = r_status;
    assign o_slot   = SLOT_W'(r_slot);
    assign o_pkts   = r_opk;
    assign o_bytes  = r_oby;

`ifndef SYNTHESIS
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL) else $error("flow count overflow");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_used) else $error("scan ran past used slots");
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SCAN && ins) |=> r_used == $past(r_used) + CW'(1))
        else $error("insert did not bump flow count");
`endif

endmodule

>>> bench/flow_counter_table_core_tb.sv
// Self-checking bench for the flow counter table: directed rows, then random traffic in phases.
module flow_counter_table_core_tb
    import fct_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = 256;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_WAIT  = 400;
    localparam int POOL_SIZE   = 40;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } t_flow_key;

    typedef struct packed {
        logic        ipv4;
        t_flow_key   key;
        logic [15:0] len;
        logic [63:0] ts;
    } t_packet;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slot;
        logic [47:0] pkts;
        logic [47:0] bytes;
    } t_flow_result;

    typedef struct {
        t_packet      pkt;
        bit           typed;
        t_flow_result res;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata;   // src, dst, sport, dport, proto, len, ts
    logic         s_axis_tuser;   // ipv4
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // slot, packets, bytes
    logic [1:0]   m_axis_tuser;   // status

    flow_counter_table_core #(.FLOW_ENTRIES(ENTRIES)) DUT (.*);

    // shadow copy of the flow table
    t_flow_key    tbl_key  [ENTRIES];
    logic [47:0]  tbl_pkts [ENTRIES];
    logic [47:0]  tbl_bytes[ENTRIES];
    int           flows_used;

    t_flow_result pending_results[$];
    t_flow_key    key_pool[POOL_SIZE];
    int           fail_count;
    int           src_idle_pct;
    int           rcv_stall_pct;
    int           hold_left;
    longint       cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_flow_result account_packet(input t_packet p);
        t_flow_result r;
        r = '0;
        r.status = ST_IGNORED;
        if (!p.ipv4) return r;
        for (int s = 0; s < flows_used; s++) begin
            if (tbl_key[s] == p.key) begin
                tbl_pkts[s]  = tbl_pkts[s] + 48'd1;
                tbl_bytes[s] = tbl_bytes[s] + {32'd0, p.len};
                r.status = ST_UPDATED;
                r.slot   = s[7:0];
                r.pkts   = tbl_pkts[s];
                r.bytes  = tbl_bytes[s];
                return r;
            end
        end
        if (flows_used >= ENTRIES) begin
            r.status = ST_DROPPED;
            return r;
        end
        tbl_key[flows_used]   = p.key;
        tbl_pkts[flows_used]  = 48'd1;
        tbl_bytes[flows_used] = {32'd0, p.len};
        r.status = ST_INSERTED;
        r.slot   = flows_used[7:0];
        r.pkts   = 48'd1;
        r.bytes  = {32'd0, p.len};
        flows_used++;
        return r;
    endfunction

    function automatic t_flow_key rand_key();
        t_flow_key k;
        k.src   = $urandom;
        k.dst   = $urandom;
        k.sport = 16'($urandom);
        k.dport = 16'($urandom);
        k.proto = 8'($urandom);
        return k;
    endfunction

    function automatic t_packet mk_pkt(input logic v, input t_flow_key k,
                                       input logic [15:0] len, input logic [63:0] ts);
        t_packet p;
        p.ipv4 = v;
        p.key  = k;
        p.len  = len;
        p.ts   = ts;
        return p;
    endfunction

    function automatic t_flow_result mk_res(input t_status st, input logic [7:0] slot,
                                            input logic [47:0] pk, input logic [47:0] by);
        t_flow_result r;
        r.status = st;
        r.slot   = slot;
        r.pkts   = pk;
        r.bytes  = by;
        return r;
    endfunction

    // drive one packet, hold it until the transfer, log the expected result
    task automatic send_packet(input t_packet p, input bit typed, input t_flow_result tr);
        t_flow_result r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= p.ipv4;
        s_axis_tdata  <= {p.ts, p.len, p.key.proto, p.key.dport, p.key.sport,
                          p.key.dst, p.key.src};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = account_packet(p);
        pending_results.push_back(typed ? tr : r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // pool traffic: mostly known flows, some near-misses, fresh keys and non-IPv4
    task automatic run_pool_phase(input int n);
        t_flow_key k;
        int        pick;
        logic      v;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            v = 1'b1;
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick < 8) begin
                k[$urandom_range(103)] ^= 1'b1;
            end else if (pick < 14) begin
                k = rand_key();
            end else if (pick < 22) begin
                v = 1'b0;
            end
            send_packet(mk_pkt(v, k, 16'($urandom), {$urandom, $urandom}), 1'b0, '0);
        end
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_flow_result got;
        t_flow_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tuser);
            got.slot   = m_axis_tdata[7:0];
            got.pkts   = m_axis_tdata[55:8];
            got.bytes  = m_axis_tdata[103:56];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d pkts=%0h bytes=%0h",
                         $time, got.status, got.slot, got.pkts, got.bytes);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                    fail_count++;
                end
                if (got.pkts !== want.pkts) begin
                    $display("%0t: packets expected %0h actual %0h", $time, want.pkts,
                             got.pkts);
                    fail_count++;
                end
                if (got.bytes !== want.bytes) begin
                    $display("%0t: bytes expected %0h actual %0h", $time, want.bytes,
                             got.bytes);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_dir_row  rows[$];
        t_flow_key k0;
        t_flow_key k1;
        t_flow_key kv;
        t_flow_key fk;
        t_flow_key seen[$];

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        fail_count    = 0;
        flows_used    = 0;
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_left     = 0;
        cycle_count   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        k0 = '0;
        k1 = '1;
        rows.push_back('{mk_pkt(1'b0, k1, 16'hFFFF, '1), 1'b1,
                         mk_res(ST_IGNORED, 8'd0, 48'd0, 48'd0)});
        rows.push_back('{mk_pkt(1'b0, k0, 16'h0, '0), 1'b1,
                         mk_res(ST_IGNORED, 8'd0, 48'd0, 48'd0)});
        rows.push_back('{mk_pkt(1'b1, k0, 16'h0, '0), 1'b1,
                         mk_res(ST_INSERTED, 8'd0, 48'd1, 48'd0)});
        rows.push_back('{mk_pkt(1'b1, k1, 16'hFFFF, '1), 1'b1,
                         mk_res(ST_INSERTED, 8'd1, 48'd1, 48'hFFFF)});
        rows.push_back('{mk_pkt(1'b1, k1, 16'hFFFF, 64'd7), 1'b1,
                         mk_res(ST_UPDATED, 8'd1, 48'd2, 48'h1FFFE)});
        rows.push_back('{mk_pkt(1'b1, k0, 16'hFFFF, 64'd8), 1'b1,
                         mk_res(ST_UPDATED, 8'd0, 48'd2, 48'hFFFF)});
        // keys differing from the zero key in a single field
        kv = k0; kv.proto = 8'd1;
        rows.push_back('{mk_pkt(1'b1, kv, 16'd5, '0), 1'b1,
                         mk_res(ST_INSERTED, 8'd2, 48'd1, 48'd5)});
        kv = k0; kv.sport = 16'd1;
        rows.push_back('{mk_pkt(1'b1, kv, 16'd5, '0), 1'b1,
                         mk_res(ST_INSERTED, 8'd3, 48'd1, 48'd5)});
        kv = k0; kv.dport = 16'd1;
        rows.push_back('{mk_pkt(1'b1, kv, 16'd5, '0), 1'b1,
                         mk_res(ST_INSERTED, 8'd4, 48'd1, 48'd5)});
        kv = k0; kv.dst = 32'd1;
        rows.push_back('{mk_pkt(1'b1, kv, 16'd5, '0), 1'b1,
                         mk_res(ST_INSERTED, 8'd5, 48'd1, 48'd5)});
        kv = k0; kv.src = 32'd1;
        rows.push_back('{mk_pkt(1'b1, kv, 16'd5, '0), 1'b1,
                         mk_res(ST_INSERTED, 8'd6, 48'd1, 48'd5)});
        rows.push_back('{mk_pkt(1'b0, k1, 16'd9, '0), 1'b1,
                         mk_res(ST_IGNORED, 8'd0, 48'd0, 48'd0)});
        rows.push_back('{mk_pkt(1'b1, k1, 16'h0, '0), 1'b1,
                         mk_res(ST_UPDATED, 8'd1, 48'd3, 48'h1FFFE)});
        kv = k0; kv.src = 32'h8000_0000;
        rows.push_back('{mk_pkt(1'b1, kv, 16'h8000, '1), 1'b0, '0});
        rows.push_back('{mk_pkt(1'b1, kv, 16'h7FFF, '0), 1'b0, '0});
        foreach (rows[i]) send_packet(rows[i].pkt, rows[i].typed, rows[i].res);
        wait_drained();

        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();

        run_pool_phase(400);
        src_idle_pct = 86;
        run_pool_phase(400);

        // pause until every result is back
        wait_drained();
        src_idle_pct  = 0;
        rcv_stall_pct = 86;
        hold_left     = 600;
        run_pool_phase(400);

        src_idle_pct  = 25;
        rcv_stall_pct = 25;
        run_pool_phase(400);

        // fill the table past capacity, mixing drops with hits
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        for (int i = 0; i < 400; i++) begin
            if (seen.size() > 0 && $urandom_range(99) < 30)
                fk = seen[$urandom_range(seen.size() - 1)];
            else begin
                fk = rand_key();
                seen.push_back(fk);
            end
            send_packet(mk_pkt($urandom_range(99) < 95, fk, 16'($urandom),
                               {$urandom, $urandom}), 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
